@@ hdl/servo_status_packet_receiver_unit_defines.svh @@
// assertion macros for the servo status packet receiver
`ifndef SERVO_STATUS_PACKET_RECEIVER_UNIT_DEFINES_SVH
`define SERVO_STATUS_PACKET_RECEIVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SSPRX_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");
`define SSPRX_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define SSPRX_ASSERT(lbl, clk, rst, prop)
`define SSPRX_NEVER(lbl, clk, rst, expr)
`endif

`endif

@@ hdl/ssprx_pkg.sv @@
// types, constants and helpers shared by the status packet receiver
package ssprx_pkg;

  localparam int WIN_LEN = 6;

  localparam logic [7:0] HDR_BYTE   = 8'hFF;
  localparam logic [7:0] ID_LIMIT   = 8'hFD;
  localparam logic [7:0] ERR_LIMIT  = 8'h7F;
  localparam logic [7:0] MIN_LENGTH = 8'd2;
  localparam logic [7:0] MAX_LENGTH_RESET = 8'd250;
  localparam logic [2:0] LAST_SLOT  = 3'd5;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  localparam logic [1:0] ST_SUCCESS = 2'd0;
  localparam logic [1:0] ST_CORRUPT = 2'd1;
  localparam logic [1:0] ST_NO_DATA = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  typedef logic [WIN_LEN-1:0][7:0] win_t;

  typedef struct packed {
    logic       burst;
    win_t       bytes;
    logic [8:0] index;
    logic       last;
    logic [1:0] status;
  } job_t;

  function automatic win_t drop_front(input win_t win, input logic [2:0] n);
    win_t       res;
    logic [3:0] j;
    for (int i = 0; i < WIN_LEN; i++) begin
      j = 4'(i) + {1'b0, n};
      if (j < 4'(WIN_LEN)) begin
        res[i] = win[j[2:0]];
      end else begin
        res[i] = 8'h00;
      end
    end
    return res;
  endfunction

endpackage

@@ hdl/ssprx_front.sv @@
// front end: hunts for the header, tracks the locked packet and issues jobs
`include "servo_status_packet_receiver_unit_defines.svh"

module ssprx_front
  import ssprx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic       cmd,
  input  logic [7:0] rx_byte,
  input  logic [7:0] max_length,
  output logic       job_push,
  output job_t       job
);

  win_t       window, window_next;
  logic [2:0] held_count, held_count_next;
  logic       locked, locked_next;
  logic [8:0] total_length, total_length_next;
  logic [8:0] position, position_next;
  logic [7:0] running_sum, running_sum_next;

  win_t       win_app;
  logic [2:0] held_app;
  logic [2:0] hdr_pos;
  logic [8:0] pos_inc;
  logic [7:0] sum3;
  logic       hdr_bad;

  always_comb begin
    win_app  = window;
    held_app = held_count;
    if (held_count < 3'(WIN_LEN)) begin
      win_app[held_count] = rx_byte;
      held_app            = held_count + 3'd1;
    end
    hdr_pos = 3'(WIN_LEN - 1);
    for (int i = WIN_LEN - 2; i >= 0; i--) begin
      if (win_app[i] == HDR_BYTE && win_app[i+1] == HDR_BYTE) begin
        hdr_pos = 3'(i);
      end
    end
  end

  assign pos_inc = position + 9'd1;
  assign sum3    = win_app[2] + win_app[3] + win_app[4];
  assign hdr_bad = (win_app[2] > ID_LIMIT) || (win_app[3] > max_length) ||
                   (win_app[3] < MIN_LENGTH) || (win_app[4] > ERR_LIMIT);

  always_comb begin
    window_next       = window;
    held_count_next   = held_count;
    locked_next       = locked;
    total_length_next = total_length;
    position_next     = position;
    running_sum_next  = running_sum;
    job_push          = 1'b0;
    job               = '0;
    job.status        = ST_NONE;
    job.bytes[0]      = rx_byte;
    job.index         = position;
    if (cmd == CMD_TIMEOUT) begin
      job_push          = 1'b1;
      job.bytes[0]      = 8'h00;
      job.index         = 9'd0;
      job.last          = 1'b1;
      job.status        = (!locked && held_count == 3'd0) ? ST_NO_DATA : ST_CORRUPT;
      window_next       = '0;
      held_count_next   = 3'd0;
      locked_next       = 1'b0;
      total_length_next = 9'(WIN_LEN);
      position_next     = 9'd0;
      running_sum_next  = 8'd0;
    end else if (locked) begin
      job_push = 1'b1;
      if (pos_inc >= total_length) begin
        job.last          = 1'b1;
        job.status        = (rx_byte == ~running_sum) ? ST_SUCCESS : ST_CORRUPT;
        window_next       = '0;
        held_count_next   = 3'd0;
        locked_next       = 1'b0;
        total_length_next = 9'(WIN_LEN);
        position_next     = 9'd0;
        running_sum_next  = 8'd0;
      end else begin
        running_sum_next = running_sum + rx_byte;
        position_next    = pos_inc;
      end
    end else begin
      window_next     = win_app;
      held_count_next = held_app;
      if (held_app == 3'(WIN_LEN)) begin
        if (hdr_pos != 3'd0) begin
          window_next     = drop_front(win_app, hdr_pos);
          held_count_next = held_app - hdr_pos;
        end else if (hdr_bad) begin
          window_next     = drop_front(win_app, 3'd1);
          held_count_next = held_app - 3'd1;
        end else begin
          job_push  = 1'b1;
          job.burst = 1'b1;
          job.bytes = win_app;
          job.index = 9'd0;
          if (win_app[3] == MIN_LENGTH) begin
            job.last          = 1'b1;
            job.status        = (win_app[5] == ~sum3) ? ST_SUCCESS : ST_CORRUPT;
            window_next       = '0;
            held_count_next   = 3'd0;
            total_length_next = 9'(WIN_LEN);
          end else begin
            locked_next       = 1'b1;
            total_length_next = {1'b0, win_app[3]} + 9'd4;
            position_next     = 9'(WIN_LEN);
            running_sum_next  = sum3 + win_app[5];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window       <= '0;
      held_count   <= 3'd0;
      locked       <= 1'b0;
      total_length <= 9'(WIN_LEN);
      position     <= 9'd0;
      running_sum  <= 8'd0;
    end else if (take) begin
      window       <= window_next;
      held_count   <= held_count_next;
      locked       <= locked_next;
      total_length <= total_length_next;
      position     <= position_next;
      running_sum  <= running_sum_next;
    end
  end

  `SSPRX_ASSERT(a_hunt_window_short, clk, rst, !locked |-> (held_count < 3'(WIN_LEN)))
  `SSPRX_ASSERT(a_lock_pos_inside, clk, rst, locked |-> (position < total_length))

endmodule

@@ hdl/ssprx_jobq.sv @@
// short job queue between the front end and the result stage
module ssprx_jobq
  import ssprx_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic take,
  output logic nonempty,
  output job_t head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_take;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head_job = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_take  = take && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_take) begin
        count <= count + 1'b1;
      end else if (do_take && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/ssprx_back.sv @@
// result stage: expands jobs into result beats held in the output register
`include "servo_status_packet_receiver_unit_defines.svh"

module ssprx_back
  import ssprx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_take,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic [8:0] byte_index,
  output logic       last,
  output logic [1:0] status
);

  logic       out_valid;
  logic [2:0] sub;
  logic       load, done, at_end;

  assign at_end   = (sub == LAST_SLOT);
  assign done     = !job.burst || at_end;
  assign load     = job_valid && (!out_valid || pop);
  assign job_take = load && done;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 3'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      sub       <= done ? 3'd0 : sub + 3'd1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (job.burst) begin
        out_byte   <= job.bytes[sub];
        byte_index <= {6'd0, sub};
        last       <= at_end && job.last;
        status     <= at_end ? job.status : ST_NONE;
      end else begin
        out_byte   <= job.bytes[0];
        byte_index <= job.index;
        last       <= job.last;
        status     <= job.status;
      end
    end
  end

  `SSPRX_NEVER(a_sub_range, clk, rst, sub > LAST_SLOT)
  `SSPRX_ASSERT(a_sub_in_burst, clk, rst, (sub != 3'd0) |-> (job_valid && job.burst))
  `SSPRX_ASSERT(a_last_has_status, clk, rst, (!empty && last) |-> (status != ST_NONE))
  `SSPRX_ASSERT(a_mid_no_status, clk, rst, (!empty && !last) |-> (status == ST_NONE))

endmodule

@@ hdl/servo_status_packet_receiver_unit.sv @@
// top level of the servo status packet receiver
//
//  port group   | handshake           | beat
//  -------------+---------------------+-------------------------------------
//  input        | push / full         | cmd, rx_byte
//  result       | empty / pop         | out_byte, byte_index, last, status
//  config       | cfg_valid/cfg_ready | cfg_data (max_length)
//
//  one input beat is taken per cycle while the job queue has room
//  results leave the output register at one per cycle while pop is high;
//  a header lock gives a burst of six results, all other jobs give one
//  a stalled result side fills the job queue, then full rises
//  rst is synchronous and clears the parser, the queue and the output;
//  max_length returns to 250
module servo_status_packet_receiver_unit
  import ssprx_pkg::*;
#(
  parameter int JOB_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       cmd,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [8:0] byte_index,
  output logic       last,
  output logic [1:0] status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0] max_length;
  logic       take;
  logic       job_push, job_take, job_valid;
  job_t       new_job, head_job;

  assign cfg_ready = 1'b1;
  assign take      = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_length <= cfg_data;
    end
  end

  ssprx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .cmd       (cmd),
    .rx_byte   (rx_byte),
    .max_length(max_length),
    .job_push  (job_push),
    .job       (new_job)
  );

  ssprx_jobq #(
    .DEPTH(JOB_DEPTH)
  ) u_jobq (
    .clk     (clk),
    .rst     (rst),
    .push    (take && job_push),
    .push_job(new_job),
    .full    (full),
    .take    (job_take),
    .nonempty(job_valid),
    .head_job(head_job)
  );

  ssprx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (head_job),
    .job_take  (job_take),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .byte_index(byte_index),
    .last      (last),
    .status    (status)
  );

endmodule

@@ bench/ssprx_checker.sv @@
`timescale 1ns / 100ps
// result checker for the status packet receiver: predicts every accepted beat and compares
module ssprx_checker
  import ssprx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic       cmd,
  input  logic [7:0] rx_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic [8:0] byte_index,
  input  logic       last,
  input  logic [1:0] status,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         waiting,
  output int         checked,
  output int         good_packets
);

  typedef struct packed {
    logic [7:0] data;
    logic [8:0] index;
    logic       last;
    logic [1:0] status;
  } pkt_result_t;

  pkt_result_t expected_results[$];
  pkt_result_t exp_r;
  pkt_result_t got_r;

  logic [7:0] win [WIN_LEN];
  int         held;
  logic       locked;
  int         total_len;
  int         pos;
  logic [7:0] run_sum;
  logic [7:0] max_len;
  int         fail_count;
  int         result_count;
  int         good_count;

  initial begin
    mismatches   = 0;
    waiting      = 0;
    checked      = 0;
    good_packets = 0;
    fail_count   = 0;
    result_count = 0;
    good_count   = 0;
  end

  task automatic restart_hunt();
    for (int i = 0; i < WIN_LEN; i++) win[i] = 8'h00;
    held      = 0;
    locked    = 1'b0;
    total_len = WIN_LEN;
    pos       = 0;
    run_sum   = 8'h00;
  endtask

  task automatic expect_result(input logic [7:0] d, input int idx, input logic l,
                               input logic [1:0] st);
    pkt_result_t r;
    r.data   = d;
    r.index  = 9'(idx);
    r.last   = l;
    r.status = st;
    expected_results.push_back(r);
  endtask

  task automatic shift_window(input int n);
    for (int i = 0; i < WIN_LEN; i++) begin
      win[i] = (i + n < WIN_LEN) ? win[i + n] : 8'h00;
    end
    held = held - n;
  endtask

  task automatic parse_rx_beat(input logic c, input logic [7:0] b);
    int         k;
    logic [7:0] chk;
    if (c == CMD_TIMEOUT) begin
      expect_result(8'h00, 0, 1'b1, (!locked && held == 0) ? ST_NO_DATA : ST_CORRUPT);
      restart_hunt();
    end else if (locked) begin
      chk = ~run_sum;
      if (pos + 1 >= total_len) begin
        expect_result(b, pos, 1'b1, (b == chk) ? ST_SUCCESS : ST_CORRUPT);
        restart_hunt();
      end else begin
        expect_result(b, pos, 1'b0, ST_NONE);
        run_sum = run_sum + b;
        pos     = pos + 1;
      end
    end else begin
      if (held < WIN_LEN) begin
        win[held] = b;
        held      = held + 1;
      end
      if (held == WIN_LEN) begin
        k = 0;
        while (k < WIN_LEN - 1 && !(win[k] == HDR_BYTE && win[k + 1] == HDR_BYTE)) k++;
        if (k != 0) begin
          shift_window(k);
        end else if (win[2] > ID_LIMIT || win[3] > max_len || win[3] < MIN_LENGTH ||
                     win[4] > ERR_LIMIT) begin
          shift_window(1);
        end else begin
          total_len = int'(win[3]) + 4;
          run_sum   = win[2] + win[3] + win[4];
          for (k = 0; k < WIN_LEN - 1; k++) expect_result(win[k], k, 1'b0, ST_NONE);
          if (total_len == WIN_LEN) begin
            chk = ~run_sum;
            expect_result(win[5], 5, 1'b1, (win[5] == chk) ? ST_SUCCESS : ST_CORRUPT);
            restart_hunt();
          end else begin
            expect_result(win[5], 5, 1'b0, ST_NONE);
            run_sum = run_sum + win[5];
            locked  = 1'b1;
            pos     = WIN_LEN;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      max_len = MAX_LENGTH_RESET;
      restart_hunt();
    end else begin
      if (pop && !empty) begin
        got_r.data   = out_byte;
        got_r.index  = byte_index;
        got_r.last   = last;
        got_r.status = status;
        result_count = result_count + 1;
        if (expected_results.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) begin
            $display("%0t: result beat with nothing expected: byte %02h index %0d last %0b status %0d",
                     $realtime, out_byte, byte_index, last, status);
          end
        end else begin
          exp_r = expected_results.pop_front();
          if (got_r !== exp_r) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10) begin
              $display("%0t: mismatch, expected byte %02h index %0d last %0b status %0d",
                       $realtime, exp_r.data, exp_r.index, exp_r.last, exp_r.status);
              $display("%0t:           got      byte %02h index %0d last %0b status %0d",
                       $realtime, got_r.data, got_r.index, got_r.last, got_r.status);
            end
          end else if (exp_r.last && exp_r.status == ST_SUCCESS) begin
            good_count = good_count + 1;
          end
        end
      end
      if (push && !full) parse_rx_beat(cmd, rx_byte);
      if (cfg_valid && cfg_ready) max_len = cfg_data;
    end
    mismatches   <= fail_count;
    waiting      <= expected_results.size();
    checked      <= result_count;
    good_packets <= good_count;
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// bench top for the status packet receiver: clock, reset, beat stimulus and verdict
module tb_top;
  import ssprx_pkg::*;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       push      = 1'b0;
  logic       cmd       = CMD_BYTE;
  logic [7:0] rx_byte   = 8'h00;
  logic       pop       = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_data  = 8'h00;

  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic [8:0] byte_index;
  logic       last;
  logic [1:0] status;
  logic       cfg_ready;

  int mismatches;
  int waiting;
  int checked;
  int good_packets;

  int         send_gap_pct   = 28;
  int         recv_stall_pct = 57;
  int         hold_req       = 0;
  int         beats_sent     = 0;
  int         timeouts_sent  = 0;
  int         settings_used  = 1;
  logic [7:0] cur_max        = MAX_LENGTH_RESET;

  servo_status_packet_receiver_unit dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .rx_byte   (rx_byte),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .byte_index(byte_index),
    .last      (last),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ssprx_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .rx_byte     (rx_byte),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .byte_index  (byte_index),
    .last        (last),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .waiting     (waiting),
    .checked     (checked),
    .good_packets(good_packets)
  );

  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // result side: random stalls, or one long hold-off when asked
  initial begin
    @(negedge rst);
    forever begin
      if (hold_req > 0) begin
        pop <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
        @(posedge clk);
      end
    end
  end

  task automatic send_beat(input logic c, input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    cmd     <= c;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    beats_sent = beats_sent + 1;
    if (c == CMD_TIMEOUT) timeouts_sent = timeouts_sent + 1;
  endtask

  task automatic send_packet(input logic [7:0] id, input logic [7:0] len,
                             input logic [7:0] err, input bit spoil, input int keep);
    logic [7:0] bytes_q[$];
    logic [7:0] sum;
    logic [7:0] p;
    bytes_q = '{HDR_BYTE, HDR_BYTE, id, len, err};
    sum = id + len + err;
    for (int i = 0; i < int'(len) - 2; i++) begin
      p   = 8'($urandom);
      sum = sum + p;
      bytes_q.push_back(p);
    end
    sum = ~sum;
    if (spoil) sum = sum ^ 8'($urandom_range(255, 1));
    bytes_q.push_back(sum);
    for (int i = 0; i < bytes_q.size() && (keep < 0 || i < keep); i++) begin
      send_beat(CMD_BYTE, bytes_q[i]);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [7:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_max       = v;
    settings_used = settings_used + 1;
  endtask

  task automatic random_unit();
    int         kind;
    int         cap;
    int         n;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] err;
    kind = $urandom_range(99);
    cap  = (cur_max < 10) ? int'(cur_max) : 10;
    id   = 8'($urandom_range(ID_LIMIT));
    err  = 8'($urandom_range(ERR_LIMIT));
    len  = 8'($urandom_range(cap, MIN_LENGTH));
    if (kind < 55) begin
      send_packet(id, len, err, $urandom_range(8) == 0, -1);
    end else if (kind < 67) begin
      case ($urandom_range(3))
        0: id  = 8'($urandom_range(255, ID_LIMIT + 1));
        1: err = 8'($urandom_range(255, ERR_LIMIT + 1));
        2: len = 8'($urandom_range(MIN_LENGTH - 1));
        default: begin
          if (cur_max < 8'd255) len = 8'($urandom_range(255, cur_max + 1));
          else id = HDR_BYTE;
        end
      endcase
      send_packet(id, len, err, 1'b0, 5 + $urandom_range(4));
    end else if (kind < 77) begin
      send_packet(id, len, err, 1'b0, $urandom_range(int'(len) + 2, 1));
      send_beat(CMD_TIMEOUT, 8'($urandom));
    end else if (kind < 90) begin
      n = $urandom_range(6, 1);
      repeat (n) send_beat(CMD_BYTE, $urandom_range(1) ? HDR_BYTE : 8'($urandom));
    end else begin
      send_beat(CMD_TIMEOUT, 8'($urandom));
    end
  endtask

  task automatic run_random(input int target);
    int start;
    start = beats_sent;
    while (beats_sent - start < target) random_unit();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(CMD_TIMEOUT, 8'hA5);
    send_packet(8'h00, MIN_LENGTH, 8'h00, 1'b0, -1);
    send_packet(ID_LIMIT, MIN_LENGTH, ERR_LIMIT, 1'b1, -1);
    send_packet(8'hFE, MIN_LENGTH, 8'h00, 1'b0, -1);
    send_beat(CMD_TIMEOUT, 8'h5A);
    send_packet(8'h01, 8'(MIN_LENGTH - 1), 8'h00, 1'b0, -1);
    send_beat(CMD_TIMEOUT, 8'hFF);

    write_max_length(MIN_LENGTH);
    run_random(12);

    send_gap_pct   = 57;
    recv_stall_pct = 28;
    write_max_length(8'd255);
    // long hold-off on the result side so the job queue backs up into full
    hold_req = 80;
    run_random(12);
    send_packet(8'h01, 8'd30, 8'h00, 1'b0, -1);

    write_max_length(8'($urandom_range(12, 3)));
    run_random(12);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    write_max_length(MAX_LENGTH_RESET);
    run_random(12);

    push <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("sent %0d input beats (%0d timeouts) under %0d max_length settings",
             beats_sent, timeouts_sent, settings_used);
    $display("checked %0d result beats, %0d packets with good checksum, %0d mismatches",
             checked, good_packets, mismatches);
    if (mismatches == 0 && waiting == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ssprx_pkg.sv
hdl/ssprx_front.sv
hdl/ssprx_jobq.sv
hdl/ssprx_back.sv
hdl/servo_status_packet_receiver_unit.sv
bench/ssprx_checker.sv
bench/tb_top.sv
